// ===== rtl/ddgs_pkg.sv =====
// ----------------------------------------------------------------------------
// ddgs_pkg
// Shared types, codes and constant tables of the go-to-point steering unit.
// ----------------------------------------------------------------------------
package ddgs_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int IN_W             = 88;
	localparam int OUT_W            = 72;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;
	localparam int MUL_W            = 16;

	localparam logic signed [33:0] HEAD_SCALE = 34'sd11930465;
	localparam int PIVOT_K    = 30;
	localparam int SLOW_K     = 150;
	localparam int CREEP_SPD  = 50;
	localparam int DUTY_DIV   = 255;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE   = 3'd0,
		CFG_MIN_DUTY = 3'd1,
		CFG_MAX_DUTY = 3'd2,
		CFG_TARGET_R = 3'd3,
		CFG_NEAR_R   = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MSTART,
		ST_MWAIT,
		ST_CWAIT,
		ST_ERR,
		ST_FLIP,
		ST_CLASS,
		ST_WSTART,
		ST_WWAIT,
		ST_WHEEL,
		ST_PSTART,
		ST_PWAIT,
		ST_QSTART,
		ST_QWAIT,
		ST_PUT,
		ST_DONE
	} state_t;

	typedef enum logic {
		WS_PIVOT,
		WS_SLOW
	} wsel_t;

	typedef struct packed {
		logic [7:0] l_mag;
		logic       l_neg;
		logic [7:0] r_mag;
		logic       r_neg;
	} wheel_t;

	function automatic wheel_t apply_rev(input logic rev, input wheel_t w);
		wheel_t o;
		o = w;
		if (rev) begin
			o.l_mag = w.r_mag;
			o.l_neg = !w.r_neg;
			o.r_mag = w.l_mag;
			o.r_neg = !w.l_neg;
		end
		return o;
	endfunction

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/ddgs_cordic.sv =====
// ----------------------------------------------------------------------------
// ddgs_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle, 32-bit angle out.
// ----------------------------------------------------------------------------
module ddgs_cordic #(
	parameter int STEPS = ddgs_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] dx,
	input  logic signed [15:0] dy,
	output logic               busy,
	output logic [31:0]        angle
);
	import ddgs_pkg::*;

	localparam int CW = $clog2(STEPS + 1);
	localparam int XW = 28;

	logic signed [XW-1:0] x_q, y_q, xs, ys, x0, y0;
	logic [31:0]          z_q;
	logic [CW-1:0]        i_q;
	logic                 zero_q;

	assign x0 = XW'(dx) <<< 8;
	assign y0 = XW'(dy) <<< 8;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign busy  = (i_q != CW'(STEPS));
	assign angle = zero_q ? 32'd0 : z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= CW'(STEPS);
		end else if (start) begin
			i_q <= '0;
		end else if (busy) begin
			i_q <= i_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == 16'sd0) && (dy == 16'sd0);
			if (dx < 16'sd0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= 32'd0;
			end
		end else if (busy) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_lut(5'(i_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_lut(5'(i_q));
			end
		end
	end

endmodule

// ===== rtl/ddgs_mul.sv =====
// ----------------------------------------------------------------------------
// ddgs_mul
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddgs_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ddgs_pkg::MUL_W-1:0]  a,
	input  logic [ddgs_pkg::MUL_W-1:0]  b,
	output logic                        busy,
	output logic [2*ddgs_pkg::MUL_W-1:0] p
);
	import ddgs_pkg::*;

	localparam int CW = $clog2(MUL_W + 1);

	logic [MUL_W-1:0]   a_q;
	logic [2*MUL_W-1:0] b_q, acc_q;
	logic [CW-1:0]      cnt_q;

	assign busy = (cnt_q != '0);
	assign p    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(MUL_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= {{MUL_W{1'b0}}, b};
			acc_q <= '0;
		end else if (busy) begin
			if (a_q[0]) begin
				acc_q <= acc_q + b_q;
			end
			a_q <= a_q >> 1;
			b_q <= b_q << 1;
		end
	end

endmodule

// ===== rtl/ddgs_div.sv =====
// ----------------------------------------------------------------------------
// ddgs_div
// Bit-serial restoring divider, one numerator bit shifted in per cycle.
// ----------------------------------------------------------------------------
module ddgs_div #(
	parameter int NW = 25,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [15:0]   q
);
	import ddgs_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q, q_q;
	logic [DW-1:0] d_q, rem_q;
	logic [DW:0]   trial;
	logic          fit;
	logic [CW-1:0] cnt_q;

	assign trial = {rem_q, n_q[NW-1]};
	assign fit   = (trial >= {1'b0, d_q});
	assign busy  = (cnt_q != '0);
	assign q     = q_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy) begin
			rem_q <= fit ? DW'(trial - {1'b0, d_q}) : DW'(trial);
			q_q   <= {q_q[NW-2:0], fit};
			n_q   <= n_q << 1;
		end
	end

endmodule

// ===== rtl/diff_drive_goto_steering_unit.sv =====
// ----------------------------------------------------------------------------
// diff_drive_goto_steering_unit
// Go-to-point steering for a differential drive: bearing, heading error,
// distance zones and duty rescale, built on bit-serial arithmetic units.
// ----------------------------------------------------------------------------
//  channel   signals                        carries
//  s_axis    tvalid tready tdata[87:0]      status, pose, goal, heading, mode, speed
//  m_axis    tvalid tready tdata[71:0]      four duties, target_reached, reversed
//  cfg       valid ready index[2:0] data    register writes, always ready
//
//  A disabled or abnormal-status item goes straight to the output. An enabled
//  item runs four serial squares, a serial divide for the wheel pair when one
//  is needed and up to two duty rescales (16-bit multiply then NW-bit divide);
//  the CORDIC runs alongside.
//  Reset clears the steering flags and loads register defaults.
//  A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module diff_drive_goto_steering_unit #(
	parameter int ANGLE_BITS   = ddgs_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = ddgs_pkg::CORDIC_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// status_normal, pos_x, pos_y, goal_x, goal_y, heading_deg, direction_mode,
	// speed_cmd, zero fill
	input  logic [ddgs_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// duty_left_fwd, duty_left_rev, duty_right_fwd, duty_right_rev,
	// target_reached, driving_reversed, zero fill
	output logic [ddgs_pkg::OUT_W-1:0]       m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ddgs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ddgs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ddgs_pkg::*;

	localparam int AB = ANGLE_BITS;
	localparam longint FULL = longint'(1) << AB;
	localparam longint DEAD_L = (FULL + 5) / 10;
	localparam logic [AB-1:0] TH_DEAD  = AB'(DEAD_L);
	localparam logic [AB-1:0] TH_CREEP = AB'((3 * FULL + 20) / 40);
	localparam logic [AB-1:0] TH_FLIP  = AB'((3 * FULL + 5) / 10);
	localparam logic [AB-1:0] HALF     = AB'(FULL / 2);
	localparam int NW = (AB + 9 > 24) ? AB + 9 : 24;
	localparam int DW = AB + 1;
	localparam logic [DW-1:0] DEN_PIVOT = DW'(2 * DEAD_L);
	localparam logic [DW-1:0] DEN_SLOW  = DW'(10 * DEAD_L);
	localparam logic [DW-1:0] DEN_DUTY  = DW'(DUTY_DIV);
	localparam logic [32:0]   RND       = 33'd1 << (31 - AB);

	state_t state_q, state_d;

	logic        en_q;
	logic [15:0] min_q, max_q, tr_q, nr_q;
	logic        rev_q, aligned_q, found_q;

	logic               sn_in;
	logic signed [15:0] px_q, py_q, gx_q, gy_q, dx_q, dy_q, dx_w, dy_w;
	logic signed [9:0]  hd_q;
	logic [1:0]         mode_q;
	logic [7:0]         spd_q;
	logic [31:0]        hdg_q, d2_q, tr2_q, nr2_q;
	logic [1:0]         sq_idx_q;
	logic [AB-1:0]      e_q, ae, bear, head, e0;
	logic               rev_n, e_pos, e_neg;
	logic [32:0]        zr, hr;
	wsel_t              wsel_q;
	wheel_t             wh_q;
	logic               spin_q, map_idx_q;
	logic [15:0]        ml_q, duty_m, diff_mag;
	logic [16:0]        diff;
	logic [15:0]        duty_q [4];
	logic [OUT_W-1:0]   out_q;
	logic               ovalid_q;
	logic [15:0]        dxa, dya;

	logic               mul_start, mul_busy, cor_start, cor_busy, div_start, div_busy;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] mul_p;
	logic [31:0]        cor_z;
	logic [NW-1:0]      div_num, num_pivot, num_slow;
	logic [DW-1:0]      div_den;
	logic [15:0]        div_q;
	logic [7:0]         map_v, wv;

	ddgs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .dx(dx_q), .dy(dy_q),
		.busy(cor_busy), .angle(cor_z)
	);

	ddgs_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .p(mul_p)
	);

	ddgs_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .q(div_q)
	);

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;
	assign sn_in         = s_axis_tdata[0];

	assign dx_w = gx_q - px_q;
	assign dy_w = gy_q - py_q;
	assign dxa  = dx_q[15] ? 16'(-dx_q) : dx_q;
	assign dya  = dy_q[15] ? 16'(-dy_q) : dy_q;

	assign zr    = {1'b0, cor_z} + RND;
	assign hr    = {1'b0, hdg_q} + RND;
	assign bear  = zr[31 -: AB];
	assign head  = hr[31 -: AB];
	assign rev_n = (mode_q == 2'd0) ? 1'b0 : (mode_q == 2'd1) ? 1'b1 : rev_q;
	assign e0    = bear - head + (rev_n ? HALF : '0);
	assign e_neg = e_q[AB-1];
	assign e_pos = !e_q[AB-1] && (e_q != '0);
	assign ae    = e_neg ? AB'(-e_q) : e_q;

	assign num_pivot = NW'(PIVOT_K) * (NW'(TH_DEAD) + NW'(ae));
	assign num_slow  = NW'(SLOW_K) * (NW'(7) * NW'(TH_DEAD) + NW'(3) * NW'(ae));
	assign wv        = div_q[7:0];

	assign diff     = {1'b0, max_q} - {1'b0, min_q};
	assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
	assign duty_m   = diff[16] ? (min_q - div_q) : (min_q + div_q);
	assign map_v    = spin_q ? spd_q : (map_idx_q ? wh_q.r_mag : wh_q.l_mag);

	always_comb begin
		mul_a = dxa;
		mul_b = dxa;
		unique case (sq_idx_q)
			2'd0: begin mul_a = dxa; mul_b = dxa; end
			2'd1: begin mul_a = dya; mul_b = dya; end
			2'd2: begin mul_a = tr_q; mul_b = tr_q; end
			2'd3: begin mul_a = nr_q; mul_b = nr_q; end
			default: ;
		endcase
		if (state_q == ST_PSTART) begin
			mul_a = {8'd0, map_v};
			mul_b = diff_mag;
		end
		if (state_q == ST_QSTART) begin
			div_num = NW'(mul_p);
			div_den = DEN_DUTY;
		end else if (wsel_q == WS_PIVOT) begin
			div_num = num_pivot;
			div_den = DEN_PIVOT;
		end else begin
			div_num = num_slow;
			div_den = DEN_SLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mul_start     = 1'b0;
		cor_start     = 1'b0;
		div_start     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (sn_in && en_q) ? ST_SETUP : ST_DONE;
				end
			end
			ST_SETUP: state_d = ST_MSTART;
			ST_MSTART: begin
				mul_start = 1'b1;
				cor_start = (sq_idx_q == 2'd0);
				state_d   = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (!mul_busy) begin
					state_d = (sq_idx_q == 2'd3) ? ST_CWAIT : ST_MSTART;
				end
			end
			ST_CWAIT: begin
				if (!cor_busy) begin
					state_d = ST_ERR;
				end
			end
			ST_ERR:  state_d = ST_FLIP;
			ST_FLIP: state_d = ST_CLASS;
			ST_CLASS: begin
				if (d2_q < tr2_q) begin
					state_d = ST_DONE;
				end else if (d2_q < nr2_q) begin
					if (ae < TH_CREEP) begin
						state_d = ST_WSTART;
					end else if (aligned_q && spd_q != 8'd0) begin
						state_d = ST_PSTART;
					end else begin
						state_d = ST_DONE;
					end
				end else if (ae > TH_DEAD) begin
					state_d = ST_PSTART;
				end else begin
					state_d = ST_WSTART;
				end
			end
			ST_WSTART: begin
				div_start = 1'b1;
				state_d   = ST_WWAIT;
			end
			ST_WWAIT: begin
				if (!div_busy) begin
					state_d = ST_WHEEL;
				end
			end
			ST_WHEEL: state_d = (spd_q != 8'd0) ? ST_PSTART : ST_DONE;
			ST_PSTART: begin
				mul_start = 1'b1;
				state_d   = ST_PWAIT;
			end
			ST_PWAIT: begin
				if (!mul_busy) begin
					state_d = ST_QSTART;
				end
			end
			ST_QSTART: begin
				div_start = 1'b1;
				state_d   = ST_QWAIT;
			end
			ST_QWAIT: begin
				if (!div_busy) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: state_d = (spin_q || map_idx_q) ? ST_DONE : ST_PSTART;
			ST_DONE: begin
				if (!ovalid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			min_q <= 16'd0;
			max_q <= 16'd255;
			tr_q  <= 16'd20;
			nr_q  <= 16'd70;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:   en_q  <= cfg_data[0];
				CFG_MIN_DUTY: min_q <= cfg_data;
				CFG_MAX_DUTY: max_q <= cfg_data;
				CFG_TARGET_R: tr_q  <= cfg_data;
				CFG_NEAR_R:   nr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q     <= 1'b0;
			aligned_q <= 1'b0;
			found_q   <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!ovalid_q || m_axis_tready)) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_ERR: begin
					rev_q   <= rev_n;
					found_q <= 1'b0;
				end
				ST_FLIP: begin
					if (mode_q == 2'd2 && ae > TH_FLIP) begin
						rev_q <= !rev_q;
					end
				end
				ST_CLASS: begin
					if (d2_q < tr2_q) begin
						found_q <= 1'b1;
					end else if (d2_q < nr2_q) begin
						aligned_q <= (ae < TH_CREEP) ? 1'b0 : !aligned_q;
					end else begin
						aligned_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				px_q   <= s_axis_tdata[16:1];
				py_q   <= s_axis_tdata[32:17];
				gx_q   <= s_axis_tdata[48:33];
				gy_q   <= s_axis_tdata[64:49];
				hd_q   <= s_axis_tdata[74:65];
				mode_q <= s_axis_tdata[76:75];
				spd_q  <= s_axis_tdata[84:77];
				for (int k = 0; k < 4; k++) begin
					duty_q[k] <= 16'd0;
				end
			end
			ST_SETUP: begin
				dx_q     <= dx_w;
				dy_q     <= dy_w;
				hdg_q    <= 32'(34'(hd_q) * HEAD_SCALE);
				sq_idx_q <= 2'd0;
			end
			ST_MWAIT: begin
				if (!mul_busy) begin
					unique case (sq_idx_q)
						2'd0: d2_q  <= mul_p;
						2'd1: d2_q  <= d2_q + mul_p;
						2'd2: tr2_q <= mul_p;
						2'd3: nr2_q <= mul_p;
						default: ;
					endcase
					sq_idx_q <= sq_idx_q + 2'd1;
				end
			end
			ST_ERR: e_q <= e0;
			ST_FLIP: begin
				if (mode_q == 2'd2 && ae > TH_FLIP) begin
					e_q <= e_q ^ HALF;
				end
			end
			ST_CLASS: begin
				map_idx_q <= 1'b0;
				spin_q    <= (d2_q >= nr2_q) && (ae > TH_DEAD);
				wsel_q    <= (d2_q < nr2_q) ? WS_PIVOT : WS_SLOW;
				wh_q      <= apply_rev(rev_q, '{8'(CREEP_SPD), 1'b0, 8'(CREEP_SPD), 1'b0});
			end
			ST_WHEEL: begin
				if (wsel_q == WS_PIVOT) begin
					wh_q <= apply_rev(rev_q, '{wv, !e_pos, wv, e_pos});
				end else if (e_neg) begin
					wh_q <= apply_rev(rev_q, '{wv, 1'b0, 8'(SLOW_K), 1'b0});
				end else begin
					wh_q <= apply_rev(rev_q, '{8'(SLOW_K), 1'b0, wv, 1'b0});
				end
			end
			ST_PUT: begin
				if (spin_q) begin
					if (e_neg) begin
						duty_q[1] <= duty_m;
						duty_q[2] <= duty_m;
					end else begin
						duty_q[0] <= duty_m;
						duty_q[3] <= duty_m;
					end
				end else if (!map_idx_q) begin
					ml_q      <= duty_m;
					map_idx_q <= 1'b1;
				end else begin
					duty_q[0] <= wh_q.l_neg ? 16'd0 : ml_q;
					duty_q[1] <= wh_q.l_neg ? ml_q : 16'd0;
					duty_q[2] <= wh_q.r_neg ? 16'd0 : duty_m;
					duty_q[3] <= wh_q.r_neg ? duty_m : 16'd0;
				end
			end
			ST_DONE: begin
				if (!ovalid_q || m_axis_tready) begin
					out_q <= {6'd0, rev_q, found_q, duty_q[3], duty_q[2], duty_q[1],
						duty_q[0]};
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the go-to-point steering unit. Directed and random
// ticks go in over the input stream and register writes over the config port.
// A local predictor works out the four duties and the steering flags for each
// accepted tick. The bench checks every output transaction against the oldest
// expected result, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
	import ddgs_pkg::*;

	localparam longint A_FULL  = 65536;
	localparam longint A_HALF  = 32768;
	localparam longint A_DEAD  = 6554;
	localparam longint A_CREEP = 4915;
	localparam longint A_FLIP  = 19661;
	localparam int     DRAIN   = 300;
	localparam int     STALL_LIMIT = 20000;

	typedef struct packed {
		logic        reversed;
		logic        reached;
		logic [15:0] rr;
		logic [15:0] rf;
		logic [15:0] lr;
		logic [15:0] lf;
	} duty_set_t;

	typedef struct {
		bit              ok;
		bit signed [15:0] px, py, gx, gy;
		bit signed [9:0] hdg;
		bit [1:0]        mode;
		bit [7:0]        spd;
	} tick_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit        en_r;
	bit [15:0] min_r, max_r, tgt_r, near_r;
	bit        rev_st, aligned_st, found_st;

	duty_set_t duty_q[$];
	int        src_idle, snk_idle;
	bit        failed;
	int        quiet;

	diff_drive_goto_steering_unit u_dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic bit [31:0] bearing32(longint dx, longint dy);
		longint x, y, xs, ys;
		bit [31:0] z;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += atan_lut(5'(i));
			end else begin
				x -= ys; y += xs; z -= atan_lut(5'(i));
			end
		end
		return z;
	endfunction

	function automatic longint to_angle(bit [31:0] z);
		bit [32:0] s;
		s = {1'b0, z} + 33'h8000;
		return longint'(s[31:16]);
	endfunction

	function automatic longint wrap_angle(longint a);
		longint u;
		u = a & (A_FULL - 1);
		return (u >= A_HALF) ? u - A_FULL : u;
	endfunction

	function automatic bit [15:0] scale_duty(longint v);
		longint r;
		r = v * (longint'(max_r) - longint'(min_r)) / 255 + longint'(min_r);
		return r[15:0];
	endfunction

	function automatic void wheels(inout duty_set_t o, input longint l, input longint r,
			input longint spd);
		longint t;
		bit [15:0] ml, mr;
		ml = 0;
		mr = 0;
		if (rev_st) begin
			t = l; l = -r; r = -t;
		end
		if (spd != 0) begin
			ml = scale_duty(l < 0 ? -l : l);
			mr = scale_duty(r < 0 ? -r : r);
		end
		o.lf = l >= 0 ? ml : 16'd0;
		o.lr = l >= 0 ? 16'd0 : ml;
		o.rf = r >= 0 ? mr : 16'd0;
		o.rr = r >= 0 ? 16'd0 : mr;
	endfunction

	function automatic duty_set_t steer(tick_t k);
		duty_set_t o;
		longint dx, dy, d2, e, ae, v, spd, bear, head;
		bit signed [15:0] ddx, ddy;
		longint hdg;
		bit [15:0] sv;
		o = '0;
		if (k.ok && en_r) begin
			ddx = k.gx - k.px;
			ddy = k.gy - k.py;
			dx = ddx;
			dy = ddy;
			d2 = dx * dx + dy * dy;
			hdg = longint'(k.hdg) * 11930465;
			bear = to_angle(bearing32(dx, dy));
			head = to_angle(hdg[31:0]);
			spd = k.spd;
			found_st = 0;
			if (k.mode == 2'd0) rev_st = 0;
			else if (k.mode == 2'd1) rev_st = 1;
			e = wrap_angle(bear - head + (rev_st ? A_HALF : 0));
			ae = e < 0 ? -e : e;
			if (k.mode == 2'd2 && ae > A_FLIP) begin
				rev_st = !rev_st;
				e = wrap_angle(e + A_HALF);
			end
			ae = e < 0 ? -e : e;
			if (d2 < longint'(tgt_r) * tgt_r) begin
				found_st = 1;
			end else if (d2 < longint'(near_r) * near_r) begin
				if (ae < A_CREEP) begin
					v = 30 * (A_DEAD + ae) / (2 * A_DEAD);
					if (e > 0) wheels(o, v, -v, spd);
					else wheels(o, -v, v, spd);
					aligned_st = 0;
				end else if (aligned_st) begin
					wheels(o, 50, 50, spd);
					aligned_st = 0;
				end else begin
					aligned_st = 1;
				end
			end else begin
				aligned_st = 0;
				if (ae > A_DEAD) begin
					sv = scale_duty(spd);
					if (e < 0) begin
						o.lr = sv; o.rf = sv;
					end else begin
						o.lf = sv; o.rr = sv;
					end
				end else begin
					v = 150 * (7 * A_DEAD + 3 * ae) / (10 * A_DEAD);
					if (e < 0) wheels(o, v, 150, spd);
					else wheels(o, 150, v, spd);
				end
			end
		end
		o.reached = found_st;
		o.reversed = rev_st;
		return o;
	endfunction

	task automatic send_tick(tick_t k);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {3'b0, k.spd, k.mode, k.hdg, k.gy, k.gx, k.py, k.px, k.ok};
		do @(posedge clk); while (!s_axis_tready);
		duty_q.push_back(steer(k));
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ENABLE:   en_r = val[0];
			CFG_MIN_DUTY: min_r = val;
			CFG_MAX_DUTY: max_r = val;
			CFG_TARGET_R: tgt_r = val;
			CFG_NEAR_R:   near_r = val;
			default: ;
		endcase
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		cfg_valid <= 0;
		while (duty_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic load_regs(bit en, bit [15:0] mn, bit [15:0] mx, bit [15:0] tr,
			bit [15:0] nr);
		drain();
		write_reg(CFG_ENABLE, {15'b0, en});
		write_reg(CFG_MIN_DUTY, mn);
		write_reg(CFG_MAX_DUTY, mx);
		write_reg(CFG_TARGET_R, tr);
		write_reg(CFG_NEAR_R, nr);
		cfg_valid <= 0;
	endtask

	function automatic tick_t mk(bit ok, int px, int py, int gx, int gy, int h, int m, int s);
		tick_t k;
		k.ok = ok;
		k.px = 16'(px); k.py = 16'(py); k.gx = 16'(gx); k.gy = 16'(gy);
		k.hdg = 10'(h); k.mode = 2'(m); k.spd = 8'(s);
		return k;
	endfunction

	function automatic tick_t rand_tick;
		tick_t k;
		int r;
		k.ok = $urandom_range(9) != 0;
		k.px = 16'($urandom);
		k.py = 16'($urandom);
		r = $urandom_range(9);
		if (r < 4) begin
			k.gx = 16'(k.px + $signed($urandom_range(200)) - 100);
			k.gy = 16'(k.py + $signed($urandom_range(200)) - 100);
		end else if (r < 7) begin
			k.gx = 16'(k.px + $signed($urandom_range(800)) - 400);
			k.gy = 16'(k.py + $signed($urandom_range(800)) - 400);
		end else begin
			k.gx = 16'($urandom);
			k.gy = 16'($urandom);
		end
		if ($urandom_range(4) != 0)
			k.hdg = 10'($signed($urandom_range(720)) - 360);
		else
			k.hdg = 10'($urandom);
		k.mode = 2'($urandom);
		r = $urandom_range(9);
		if (r == 0)
			k.spd = 8'd0;
		else if (r == 1)
			k.spd = 8'd255;
		else
			k.spd = 8'($urandom);
		return k;
	endfunction

	task automatic test_disabled;
		send_tick(mk(1, 0, 0, 500, 0, 0, 0, 200));
		send_tick(mk(1, 0, 0, 10, 0, 0, 1, 200));
	endtask

	task automatic test_directed;
		load_regs(1, 16'd1000, 16'd60000, 16'd20, 16'd70);
		send_tick(mk(0, 0, 0, 500, 0, 0, 0, 200));
		send_tick(mk(1, 5, 5, 5, 5, 0, 0, 100));
		send_tick(mk(1, 0, 0, 500, 0, 0, 0, 255));
		send_tick(mk(1, 0, 0, 500, 30, 0, 0, 128));
		send_tick(mk(1, 0, 0, 500, 0, 90, 0, 200));
		send_tick(mk(1, 0, 0, 500, 0, -90, 0, 200));
		send_tick(mk(1, 0, 0, 500, 0, 180, 0, 200));
		send_tick(mk(1, 0, 0, 500, 0, 0, 1, 200));
		send_tick(mk(1, 0, 0, 500, 0, 170, 2, 200));
		send_tick(mk(1, 0, 0, 500, 0, 0, 3, 200));
		send_tick(mk(1, 0, 0, 40, 0, 3, 0, 200));
		send_tick(mk(1, 0, 0, 40, 0, -3, 0, 200));
		send_tick(mk(1, 0, 0, 40, 0, 90, 0, 200));
		send_tick(mk(1, 0, 0, 40, 0, 90, 0, 200));
		send_tick(mk(1, 0, 0, 40, 0, 90, 0, 200));
		send_tick(mk(1, 0, 0, 3, 4, 0, 0, 200));
		send_tick(mk(1, 0, 0, 500, 0, 0, 0, 0));
		send_tick(mk(1, 0, 0, 40, 0, 3, 0, 0));
		send_tick(mk(1, 0, 0, 500, 0, 90, 0, 0));
		send_tick(mk(1, -32768, -32768, 32767, 32767, 360, 2, 255));
		send_tick(mk(1, 32767, 32767, -32768, -32768, -360, 2, 1));
		send_tick(mk(1, 0, 0, 300, -300, -512, 2, 77));
		send_tick(mk(1, 0, 0, -300, 300, 511, 3, 77));
	endtask

	task automatic test_random(int n);
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: load_regs(1, 16'd0, 16'd65535, 16'd20, 16'd70);
				1: load_regs(1, 16'd65535, 16'd0, 16'd0, 16'd65535);
				2: load_regs(1, 16'd1234, 16'd50000, 16'd60, 16'd200);
				3: load_regs(0, 16'd100, 16'd200, 16'd20, 16'd70);
				default: load_regs(1, 16'd500, 16'd500, 16'd65535, 16'd0);
			endcase
			for (int i = 0; i < (p == 3 ? n / 10 : n / 4); i++)
				send_tick(rand_tick());
		end
	endtask

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= snk_idle);

	always @(posedge clk) begin
		duty_set_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[65:0];
			if (duty_q.size() == 0) begin
				$error("unexpected output transaction %h", got);
				failed = 1;
			end else begin
				want = duty_q.pop_front();
				if (got.lf != want.lf) begin
					$error("duty_left_fwd exp %0d got %0d", want.lf, got.lf); failed = 1;
				end
				if (got.lr != want.lr) begin
					$error("duty_left_rev exp %0d got %0d", want.lr, got.lr); failed = 1;
				end
				if (got.rf != want.rf) begin
					$error("duty_right_fwd exp %0d got %0d", want.rf, got.rf); failed = 1;
				end
				if (got.rr != want.rr) begin
					$error("duty_right_rev exp %0d got %0d", want.rr, got.rr); failed = 1;
				end
				if (got.reached != want.reached) begin
					$error("target_reached exp %0d got %0d", want.reached, got.reached);
					failed = 1;
				end
				if (got.reversed != want.reversed) begin
					$error("driving_reversed exp %0d got %0d", want.reversed, got.reversed);
					failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		en_r = 0; min_r = 0; max_r = 255; tgt_r = 20; near_r = 70;
		rev_st = 0; aligned_st = 0; found_st = 0;
		src_idle = 0; snk_idle = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_disabled();
		test_directed();
		src_idle = 38; snk_idle = 52;
		test_random(372);
		src_idle = 52; snk_idle = 38;
		test_random(372);
		src_idle = 0; snk_idle = 0;
		test_random(372);
		drain();
		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
